// File: hw/rtl/kcc_pkg.sv
// Package for the Kelvin contact check sequencer.
// Holds the op codes, sizing constants, result beat layout and the bridge word table.
// Depends on nothing; the sequencer uses it by scoped names.
package kcc_pkg;

    // Op codes carried in the input tuser field.
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;

    localparam int PROBES      = 4;
    localparam int OVERSAMPLE  = 16;
    localparam int SAMPLE_BITS = 12;

    localparam int OS_SHIFT   = $clog2(OVERSAMPLE);
    localparam int SUM_BITS   = SAMPLE_BITS + OS_SHIFT;
    localparam int PROBE_BITS = $clog2(PROBES + 1);
    localparam int IDX_BITS   = $clog2(PROBES);
    localparam int TIME_BITS  = 16;
    localparam int WORD_BITS  = 16;

    // Verdict pattern for full mode: probes 0 and 3 conduct, 1 and 2 do not.
    localparam logic [PROBES-1:0] PASS_PATTERN = 4'b1001;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PROBE_TIME = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD  = 2'd1;
    localparam logic [1:0] CFG_FULL_TEST  = 2'd2;
    localparam logic [1:0] CFG_BRIDGE     = 2'd3;

    // One result beat, listed from the highest bit down.
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] measured_value;
        logic [IDX_BITS-1:0]    measured_index;
        logic                   measured_valid;
        logic                   adc_start;
        logic                   bridge_write;
        logic [WORD_BITS-1:0]   bridge_word;
        logic [PROBES-1:0]      probe_results;
        logic                   cc_short;
        logic                   passed;
        logic                   done_res;
    } t_result;

    // Relay arm bits for each probe step; the step after the last one
    // leaves only the base bits.
    function automatic logic [WORD_BITS-1:0] arm_bits(input logic [PROBE_BITS-1:0] probe);
        logic [WORD_BITS-1:0] w;
        begin
            case (probe)
                3'd0:    w = 16'h0009;
                3'd1:    w = 16'h0012;
                3'd2:    w = 16'h000C;
                3'd3:    w = 16'h0021;
                default: w = 16'h0000;
            endcase
            return w;
        end
    endfunction

endpackage

// File: hw/rtl/kelvin_contact_check_sequencer.sv
// Top level of the Kelvin contact check sequencer.
// Uses kcc_pkg for op codes, sizes, the result layout and the bridge word table.

// The sequencer takes one beat per clock on its input stream and gives exactly one
// result beat for each, in the cycle after acceptance, from a single output register.
// The whole state update (sample accumulation, tick counting, probe compare and
// verdict) is done by short logic between the accepted beat and that register, so a
// new beat is taken in every cycle in which the output register is empty or is being
// drained; a stalled consumer holds the input back only while the register is full.
// The input tuser carries the op (start, tick, ADC sample) and tdata the sample.
// A start returns the block to its prepare phase and clears the sample accumulation;
// the next tick drives the bridge word for probe 0. Each later tick counts toward
// probe_time: one tick early it strobes adc_start, and at probe_time it compares the
// latest 16-sample average with the threshold, reports that value, writes the next
// bridge word and clears the average. After the fourth probe it reports the verdict,
// then repeats that verdict on every further tick until the next start. Configuration
// is to be written through the plain write port only while the block is idle, a rule
// the block does not enforce; writes act at once; full_test is read when the verdict is formed.

module kelvin_contact_check_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [11:0] sample, [15:12] zero
    input  logic [1:0]  s_axis_tuser,  // [1:0] op
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // [0] done_res, [1] passed, [2] cc_short,
                                       // [6:3] probe_results, [22:7] bridge_word,
                                       // [23] bridge_write, [24] adc_start,
                                       // [25] measured_valid, [27:26] measured_index,
                                       // [39:28] measured_value
);

    localparam logic [1:0] PH_PREPARE = 2'd0;
    localparam logic [1:0] PH_PROCESS = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;

    // Configuration registers.
    logic [kcc_pkg::TIME_BITS-1:0]   r_probe_time;
    logic [kcc_pkg::SAMPLE_BITS-1:0] r_threshold;
    logic                            r_full_test;
    logic [kcc_pkg::WORD_BITS-1:0]   r_bridge_base;

    // Sequencer state.
    logic [1:0]                          r_phase,  n_phase;
    logic [kcc_pkg::TIME_BITS-1:0]       r_tick,   n_tick;
    logic [kcc_pkg::PROBE_BITS-1:0]      r_probe,  n_probe;
    logic [kcc_pkg::SAMPLE_BITS-1:0]     r_avg,    n_avg;
    logic [kcc_pkg::SUM_BITS-1:0]        r_sum,    n_sum;
    logic [kcc_pkg::OS_SHIFT-1:0]        r_cnt,    n_cnt;
    logic [kcc_pkg::PROBES-1:0]          r_res,    n_res;

    // Output register.
    logic             r_out_valid;
    kcc_pkg::t_result r_out, n_out;

    logic                            in_accept;
    logic [1:0]                      in_op;
    logic [kcc_pkg::SAMPLE_BITS-1:0] in_sample;
    logic [kcc_pkg::SUM_BITS-1:0]    sum_add;
    logic [kcc_pkg::TIME_BITS-1:0]   tick_inc;
    logic [kcc_pkg::IDX_BITS-1:0]    idx;
    logic [kcc_pkg::PROBE_BITS-1:0]  probe_inc;
    logic [kcc_pkg::PROBES-1:0]      res_upd;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_op         = s_axis_tuser;
    assign in_sample     = s_axis_tdata[kcc_pkg::SAMPLE_BITS-1:0];

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    assign sum_add   = r_sum + kcc_pkg::SUM_BITS'(in_sample);
    assign tick_inc  = r_tick + 1'b1;
    assign idx       = r_probe[kcc_pkg::IDX_BITS-1:0];
    assign probe_inc = r_probe + 1'b1;

    // The result bits with the current probe's compare folded in.
    always_comb begin
        res_upd      = r_res;
        res_upd[idx] = (r_avg > r_threshold);
    end

    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_probe = r_probe;
        n_avg   = r_avg;
        n_sum   = r_sum;
        n_cnt   = r_cnt;
        n_res   = r_res;
        n_out   = '0;

        case (in_op)
            kcc_pkg::OP_START: begin
                n_phase = PH_PREPARE;
                n_sum   = '0;
                n_cnt   = '0;
            end
            kcc_pkg::OP_SAMPLE: begin
                // Every OVERSAMPLE-th sample closes a block and sets the average.
                if (r_cnt == kcc_pkg::OS_SHIFT'(kcc_pkg::OVERSAMPLE - 1)) begin
                    n_avg = sum_add[kcc_pkg::SUM_BITS-1:kcc_pkg::OS_SHIFT];
                    n_sum = '0;
                    n_cnt = '0;
                end else begin
                    n_sum = sum_add;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            kcc_pkg::OP_TICK: begin
                if (r_phase == PH_PREPARE) begin
                    n_tick             = '0;
                    n_probe            = '0;
                    n_res              = '0;
                    n_out.bridge_word  = r_bridge_base | kcc_pkg::arm_bits('0);
                    n_out.bridge_write = 1'b1;
                    n_phase            = PH_PROCESS;
                end else if (r_phase == PH_PROCESS) begin
                    n_tick = tick_inc;
                    if (tick_inc == r_probe_time) begin
                        n_tick               = '0;
                        n_res                = res_upd;
                        n_out.measured_valid = 1'b1;
                        n_out.measured_index = idx;
                        n_out.measured_value = r_avg;
                        n_probe              = probe_inc;
                        n_out.bridge_word    = r_bridge_base | kcc_pkg::arm_bits(probe_inc);
                        n_out.bridge_write   = 1'b1;
                        n_avg                = '0;
                        if (probe_inc >= kcc_pkg::PROBE_BITS'(kcc_pkg::PROBES)) begin
                            n_phase             = PH_DONE;
                            n_out.done_res      = 1'b1;
                            n_out.probe_results = res_upd;
                            if (r_full_test) begin
                                n_out.passed = (res_upd == kcc_pkg::PASS_PATTERN);
                            end else begin
                                n_out.passed   = !(res_upd[1] || res_upd[2]);
                                n_out.cc_short = res_upd[1] || res_upd[2];
                            end
                        end
                    end else if (tick_inc == r_probe_time - 1'b1) begin
                        n_out.adc_start = 1'b1;
                    end
                end else begin
                    // Done: repeat the verdict with no strobes.
                    n_out.done_res      = 1'b1;
                    n_out.probe_results = r_res;
                    if (r_full_test) begin
                        n_out.passed = (r_res == kcc_pkg::PASS_PATTERN);
                    end else begin
                        n_out.passed   = !(r_res[1] || r_res[2]);
                        n_out.cc_short = r_res[1] || r_res[2];
                    end
                end
            end
            default: begin
                // Unused op: no state change, an all-zero result.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe_time  <= kcc_pkg::TIME_BITS'(100);
            r_threshold   <= '0;
            r_full_test   <= 1'b0;
            r_bridge_base <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                kcc_pkg::CFG_PROBE_TIME: r_probe_time  <= i_cfg_data;
                kcc_pkg::CFG_THRESHOLD:  r_threshold   <= i_cfg_data[kcc_pkg::SAMPLE_BITS-1:0];
                kcc_pkg::CFG_FULL_TEST:  r_full_test   <= i_cfg_data[0];
                kcc_pkg::CFG_BRIDGE:     r_bridge_base <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_PREPARE;
            r_tick      <= '0;
            r_probe     <= '0;
            r_avg       <= '0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_res       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_phase     <= n_phase;
                r_tick      <= n_tick;
                r_probe     <= n_probe;
                r_avg       <= n_avg;
                r_sum       <= n_sum;
                r_cnt       <= n_cnt;
                r_res       <= n_res;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

`ifndef ASSERT_OFF
    a_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_probe <= kcc_pkg::PROBE_BITS'(kcc_pkg::PROBES))
        else $error("probe counter beyond last probe");

    a_done_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DONE |-> r_probe == kcc_pkg::PROBE_BITS'(kcc_pkg::PROBES))
        else $error("done phase without all probes measured");

    a_measure_bridge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.measured_valid |-> r_out.bridge_write)
        else $error("measurement reported without bridge switch");

    a_adc_vs_measure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.adc_start && r_out.measured_valid))
        else $error("adc start and measurement on the same beat");

    a_tick_after_prepare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && in_op == kcc_pkg::OP_TICK && r_phase == PH_PREPARE
        |=> r_phase == PH_PROCESS && r_out.bridge_write)
        else $error("first tick did not start the probe sequence");
`endif

endmodule
